/* design/bramwm_pkg.sv */
// Package: shared constants and types for the banked RAM with access watermarks.
`timescale 1ns / 1ps

package bramwm_pkg;

   localparam int DEFAULT_BANK_COUNT = 16;
   localparam int DEFAULT_BANK_BYTES = 4096;

   localparam int ADDR_W      = 16;
   localparam int WORD_W      = 16;
   localparam int MARK_HIGH_W = 17;
   localparam int MAP_W       = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [ADDR_W-1:0] EMPTY_LOW = 16'hFFFF;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic {
      CSR_BANK_MAP = 1'b0,
      CSR_UNUSED   = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE0,
      ST_BYTE1,
      ST_MARK_LO,
      ST_MARK_HI,
      ST_FINISH
   } state_type;

endpackage

/* design/banked_ram_with_access_watermarks.sv */
// Top level: banked byte RAM with 16-bit word access and per-bank watermarks.
// Each item steps through BYTE0, BYTE1, MARK_LO, MARK_HI and FINISH; one whose first bank
//   is absent goes from BYTE0 straight to FINISH, and a full output register holds it there.
// A new item is taken only in IDLE, once the last is handed over; the sequencer walks
//   one byte memory port twice and one 17-bit comparator twice per mapped item.
// Reset (synchronous, active high): bank map 0, watermarks empty, no item in flight.
//   The byte memory is not cleared.
`timescale 1ns / 1ps

module banked_ram_with_access_watermarks #(
   parameter int BANK_COUNT = bramwm_pkg::DEFAULT_BANK_COUNT,
   parameter int BANK_BYTES = bramwm_pkg::DEFAULT_BANK_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [bramwm_pkg::ADDR_W-1:0]       req_address,
   input  logic [bramwm_pkg::WORD_W-1:0]       req_write_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bramwm_pkg::WORD_W-1:0]       rsp_read_data,
   output logic                                rsp_mapped,
   output logic [bramwm_pkg::ADDR_W-1:0]       rsp_range_low,
   output logic [bramwm_pkg::MARK_HIGH_W-1:0]  rsp_range_high,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bramwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bramwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bramwm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int ADDR_W      = bramwm_pkg::ADDR_W;
   localparam int WORD_W      = bramwm_pkg::WORD_W;
   localparam int HIGH_W      = bramwm_pkg::MARK_HIGH_W;
   localparam int MAP_W       = bramwm_pkg::MAP_W;
   localparam int BANK_SHIFT  = $clog2(BANK_BYTES);
   localparam int BANK_NUM_W  = ADDR_W - BANK_SHIFT;
   localparam int BANK_IDX_W  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int MEM_BYTES   = BANK_COUNT * BANK_BYTES;
   localparam int MEM_ADDR_W  = $clog2(MEM_BYTES);

   // ------------------------------------------------------------------
   // Configuration: one register, bank_map, at byte address 0. The word
   // index is paddr[2]; any other word is ignored on write and reads 0.
   // ------------------------------------------------------------------
   logic [MAP_W-1:0] bank_map_ff;
   logic             csr_write;
   logic             csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (bramwm_pkg::csr_reg_type'(csr_paddr[2]) == bramwm_pkg::CSR_BANK_MAP);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_map_ff <= '0;
      end else if (csr_write && csr_hit) begin
         bank_map_ff <= csr_pwdata[MAP_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? {{(bramwm_pkg::CSR_DATA_W-MAP_W){1'b0}}, bank_map_ff} : '0;

   // ------------------------------------------------------------------
   // Item registers, captured on accept.
   // ------------------------------------------------------------------
   bramwm_pkg::state_type state_ff, state_in;
   logic                  op_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [WORD_W-1:0]     wdata_ff;

   assign req_ready = (state_ff == bramwm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= req_operation;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
   end

   // Bank decode for both bytes. The second byte wraps at the top of memory,
   // but its watermark candidate keeps the carry (addr + 1 may be 0x10000).
   logic [HIGH_W-1:0]     addr_p1;
   logic [ADDR_W-1:0]     addr2;
   logic [BANK_NUM_W-1:0] bank1;
   logic [BANK_NUM_W-1:0] bank2;
   logic                  in_range1;
   logic                  in_range2;
   logic                  present1;
   logic                  present2;
   logic [BANK_IDX_W-1:0] mark_idx;
   logic                  is_write;

   assign addr_p1   = {1'b0, addr_ff} + HIGH_W'(1);
   assign addr2     = addr_p1[ADDR_W-1:0];
   assign bank1     = BANK_NUM_W'(addr_ff >> BANK_SHIFT);
   assign bank2     = BANK_NUM_W'(addr2 >> BANK_SHIFT);
   // Compare one bit wider: a full set of banks does not fit the bank number.
   assign in_range1 = ({1'b0, bank1} < (BANK_NUM_W+1)'(BANK_COUNT));
   assign in_range2 = ({1'b0, bank2} < (BANK_NUM_W+1)'(BANK_COUNT));
   // Banks beyond BANK_COUNT are absent no matter what the map says.
   assign present1  = in_range1 && bank_map_ff[bank1[3:0]];
   assign present2  = in_range2 && bank_map_ff[bank2[3:0]];
   assign mark_idx  = bank2[BANK_IDX_W-1:0];
   assign is_write  = (bramwm_pkg::op_type'(op_ff) == bramwm_pkg::OP_WRITE);

   // ------------------------------------------------------------------
   // Byte memory: a single port, shared by the low and the high byte.
   // ------------------------------------------------------------------
   logic [7:0]            mem [MEM_BYTES];
   logic [7:0]            mem_rdata_ff;
   logic [MEM_ADDR_W-1:0] mem_addr;
   logic                  mem_we;
   logic [7:0]            mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // ------------------------------------------------------------------
   // Watermarks: one low/high pair per bank for reads and one for writes.
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0] rd_low_ff  [BANK_COUNT];
   logic [HIGH_W-1:0] rd_high_ff [BANK_COUNT];
   logic [ADDR_W-1:0] wr_low_ff  [BANK_COUNT];
   logic [HIGH_W-1:0] wr_high_ff [BANK_COUNT];
   logic [ADDR_W-1:0] low_cur;
   logic [HIGH_W-1:0] high_cur;

   assign low_cur  = is_write ? wr_low_ff[mark_idx]  : rd_low_ff[mark_idx];
   assign high_cur = is_write ? wr_high_ff[mark_idx] : rd_high_ff[mark_idx];

   // Shared comparator: min against the low mark, then max against the high mark.
   logic [HIGH_W-1:0] cmp_a;
   logic [HIGH_W-1:0] cmp_b;
   logic              cmp_lt;
   logic [HIGH_W-1:0] mark_new;
   logic              on_low;

   assign on_low   = (state_ff == bramwm_pkg::ST_MARK_LO);
   assign cmp_a    = on_low ? {1'b0, addr_ff} : high_cur;
   assign cmp_b    = on_low ? {1'b0, low_cur} : addr_p1;
   assign cmp_lt   = (cmp_a < cmp_b);
   assign mark_new = on_low ? (cmp_lt ? cmp_a : cmp_b) : (cmp_lt ? cmp_b : cmp_a);

   // ------------------------------------------------------------------
   // Working result and output register.
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] rd_word_ff, rd_word_in;
   logic              mapped_ff,  mapped_in;
   logic [ADDR_W-1:0] lo_ff,      lo_in;
   logic [HIGH_W-1:0] hi_ff,      hi_in;
   logic              low_upd;
   logic              high_upd;
   logic              load_rsp;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_read_data_ff;
   logic              rsp_mapped_ff;
   logic [ADDR_W-1:0] rsp_range_low_ff;
   logic [HIGH_W-1:0] rsp_range_high_ff;

   // Sequencer: next state, memory port and datapath controls.
   always_comb begin
      state_in   = state_ff;
      rd_word_in = rd_word_ff;
      mapped_in  = mapped_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      low_upd    = 1'b0;
      high_upd   = 1'b0;
      load_rsp   = 1'b0;
      mem_addr   = addr_ff[MEM_ADDR_W-1:0];
      mem_we     = 1'b0;
      mem_wdata  = wdata_ff[7:0];
      unique case (state_ff)
         bramwm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bramwm_pkg::ST_BYTE0;
            end
         end
         bramwm_pkg::ST_BYTE0: begin
            // Low byte: write it, or issue its read.
            rd_word_in = '0;
            if (present1) begin
               mem_we    = is_write;
               mapped_in = 1'b1;
               lo_in     = bramwm_pkg::EMPTY_LOW;
               hi_in     = '0;
               state_in  = bramwm_pkg::ST_BYTE1;
            end else begin
               // Absent first bank: drop the access, report all zeros.
               mapped_in = 1'b0;
               lo_in     = '0;
               hi_in     = '0;
               state_in  = bramwm_pkg::ST_FINISH;
            end
         end
         bramwm_pkg::ST_BYTE1: begin
            // High byte: stored only if its bank is present.
            mem_addr  = addr2[MEM_ADDR_W-1:0];
            mem_we    = is_write && present2;
            mem_wdata = wdata_ff[15:8];
            if (!is_write) begin
               rd_word_in[7:0] = mem_rdata_ff;
            end
            state_in = bramwm_pkg::ST_MARK_LO;
         end
         bramwm_pkg::ST_MARK_LO: begin
            // An absent second bank reads as zero.
            if (!is_write && present2) begin
               rd_word_in[15:8] = mem_rdata_ff;
            end
            if (in_range2) begin
               low_upd = 1'b1;
               lo_in   = mark_new[ADDR_W-1:0];
            end
            state_in = bramwm_pkg::ST_MARK_HI;
         end
         bramwm_pkg::ST_MARK_HI: begin
            if (in_range2) begin
               high_upd = 1'b1;
               hi_in    = mark_new;
            end
            state_in = bramwm_pkg::ST_FINISH;
         end
         bramwm_pkg::ST_FINISH: begin
            // Hand over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = bramwm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bramwm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bramwm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff <= rd_word_in;
      mapped_ff  <= mapped_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
   end

   // Watermark write-back into the second byte's bank.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANK_COUNT; i++) begin
            rd_low_ff[i]  <= bramwm_pkg::EMPTY_LOW;
            rd_high_ff[i] <= '0;
            wr_low_ff[i]  <= bramwm_pkg::EMPTY_LOW;
            wr_high_ff[i] <= '0;
         end
      end else begin
         if (low_upd) begin
            if (is_write) begin
               wr_low_ff[mark_idx] <= mark_new[ADDR_W-1:0];
            end else begin
               rd_low_ff[mark_idx] <= mark_new[ADDR_W-1:0];
            end
         end
         if (high_upd) begin
            if (is_write) begin
               wr_high_ff[mark_idx] <= mark_new;
            end else begin
               rd_high_ff[mark_idx] <= mark_new;
            end
         end
      end
   end

   // Output register: hold the result until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_read_data_ff  <= rd_word_ff;
         rsp_mapped_ff     <= mapped_ff;
         rsp_range_low_ff  <= lo_ff;
         rsp_range_high_ff <= hi_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_mapped     = rsp_mapped_ff;
   assign rsp_range_low  = rsp_range_low_ff;
   assign rsp_range_high = rsp_range_high_ff;

endmodule

/* design/bramwm_checker.sv */
// Checker: port-level assertions for the banked RAM, with its bind statement.
`timescale 1ns / 1ps

module bramwm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_operation,
   input logic [bramwm_pkg::ADDR_W-1:0]       req_address,
   input logic [bramwm_pkg::WORD_W-1:0]       req_write_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bramwm_pkg::WORD_W-1:0]       rsp_read_data,
   input logic                                rsp_mapped,
   input logic [bramwm_pkg::ADDR_W-1:0]       rsp_range_low,
   input logic [bramwm_pkg::MARK_HIGH_W-1:0]  rsp_range_high,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [bramwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [bramwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [bramwm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                                csr_pready
);

   // A stalled item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_mapped) && $stable(rsp_range_low) && $stable(rsp_range_high))
      else $error("response changed while stalled");

   // One item at a time: ready drops right after an accept.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A dropped access reports all zeros.
   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mapped |-> rsp_read_data == '0 && rsp_range_low == '0
         && rsp_range_high == '0)
      else $error("unmapped access with nonzero result");

   // A nonempty range always has low below high.
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapped && rsp_range_high != '0
         |-> {1'b0, rsp_range_low} < rsp_range_high)
      else $error("watermark range out of order");

   // The configuration port never stalls.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("pready low");

endmodule

bind banked_ram_with_access_watermarks bramwm_checker u_checker (.*);

/* test/bramwm_checker.sv */
// Scoreboard: predicts each banked RAM access and compares it with the response channel.
`timescale 1ns / 1ps

module bramwm_scoreboard #(
   parameter int BANK_COUNT = bramwm_pkg::DEFAULT_BANK_COUNT,
   parameter int BANK_BYTES = bramwm_pkg::DEFAULT_BANK_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_operation,
   input  logic [bramwm_pkg::ADDR_W-1:0]       req_address,
   input  logic [bramwm_pkg::WORD_W-1:0]       req_write_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [bramwm_pkg::WORD_W-1:0]       rsp_read_data,
   input  logic                                rsp_mapped,
   input  logic [bramwm_pkg::ADDR_W-1:0]       rsp_range_low,
   input  logic [bramwm_pkg::MARK_HIGH_W-1:0]  rsp_range_high,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bramwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bramwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [bramwm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  requests_seen,
   output int                                  results_seen
);
   localparam int WORD_W      = bramwm_pkg::WORD_W;
   localparam int ADDR_W      = bramwm_pkg::ADDR_W;
   localparam int MARK_HIGH_W = bramwm_pkg::MARK_HIGH_W;
   localparam int MAP_W       = bramwm_pkg::MAP_W;
   localparam int CSR_ADDR_W  = bramwm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W  = bramwm_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [WORD_W-1:0]      read_data;
      logic                   mapped;
      logic [ADDR_W-1:0]      range_low;
      logic [MARK_HIGH_W-1:0] range_high;
   } access_result_type;

   logic [7:0]             mem_image [0:65535];
   // first index: 0 for reads, 1 for writes
   logic [ADDR_W-1:0]      low_mark  [0:1][0:BANK_COUNT-1];
   logic [MARK_HIGH_W-1:0] high_mark [0:1][0:BANK_COUNT-1];
   logic [MAP_W-1:0]       bank_map;
   access_result_type      expected_results [$];

   function automatic bit bank_present(input int bank);
      return bank < BANK_COUNT && bank < 16 && bank_map[bank];
   endfunction

   task automatic model_access(input bramwm_pkg::op_type op, input logic [ADDR_W-1:0] addr,
                               input logic [WORD_W-1:0] data,
                               output access_result_type res);
      logic [ADDR_W-1:0]      addr2;
      logic [MARK_HIGH_W-1:0] addr_end;
      int                     bank1;
      int                     bank2;
      int                     kind;
      bit                     second_ok;
      addr2     = addr + 16'd1;
      addr_end  = {1'b0, addr} + 17'd1;
      bank1     = int'(addr) / BANK_BYTES;
      bank2     = int'(addr2) / BANK_BYTES;
      second_ok = bank_present(bank2);
      kind      = (op == bramwm_pkg::OP_WRITE) ? 1 : 0;
      res       = '0;
      if (bank_present(bank1)) begin
         res.mapped    = 1'b1;
         res.range_low = bramwm_pkg::EMPTY_LOW;
         if (op == bramwm_pkg::OP_WRITE) begin
            mem_image[addr] = data[7:0];
            if (second_ok) mem_image[addr2] = data[15:8];
         end else begin
            res.read_data[7:0] = mem_image[addr];
            if (second_ok) res.read_data[15:8] = mem_image[addr2];
         end
         // marks are charged to the bank of the second byte
         if (bank2 < BANK_COUNT) begin
            if (addr < low_mark[kind][bank2]) low_mark[kind][bank2] = addr;
            if (addr_end > high_mark[kind][bank2]) high_mark[kind][bank2] = addr_end;
            res.range_low  = low_mark[kind][bank2];
            res.range_high = high_mark[kind][bank2];
         end
      end
   endtask

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      access_result_type want;
      access_result_type got;
      int                k;
      int                b;
      if (reset) begin
         for (k = 0; k < 2; k++) begin
            for (b = 0; b < BANK_COUNT; b++) begin
               low_mark[k][b]  = bramwm_pkg::EMPTY_LOW;
               high_mark[k][b] = '0;
            end
         end
         bank_map = '0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == bramwm_pkg::CSR_BANK_MAP) begin
            if (csr_pwrite) begin
               bank_map = csr_pwdata[MAP_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(bank_map)) begin
               $error("bank_map readback: expected %h, got %h", bank_map, csr_prdata);
               fail_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", 17'(want.read_data), 17'(rsp_read_data));
               check_field("mapped", 17'(want.mapped), 17'(rsp_mapped));
               check_field("range_low", 17'(want.range_low), 17'(rsp_range_low));
               check_field("range_high", want.range_high, rsp_range_high);
            end
         end
         if (req_valid && req_ready) begin
            requests_seen++;
            model_access(bramwm_pkg::op_type'(req_operation), req_address, req_write_data,
                         got);
            expected_results.push_back(got);
         end
      end
      pending = expected_results.size();
   end

endmodule

/* test/banked_ram_with_access_watermarks_tb.sv */
// Testbench top: drives accesses and bank map settings into the banked RAM and gives the verdict.
`timescale 1ns / 1ps

module banked_ram_with_access_watermarks_tb;

   localparam int ADDR_W             = bramwm_pkg::ADDR_W;
   localparam int WORD_W             = bramwm_pkg::WORD_W;
   localparam int MARK_HIGH_W        = bramwm_pkg::MARK_HIGH_W;
   localparam int MAP_W              = bramwm_pkg::MAP_W;
   localparam int CSR_ADDR_W         = bramwm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W         = bramwm_pkg::CSR_DATA_W;
   localparam int DEFAULT_BANK_COUNT = bramwm_pkg::DEFAULT_BANK_COUNT;
   localparam int DEFAULT_BANK_BYTES = bramwm_pkg::DEFAULT_BANK_BYTES;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 600;   // results seen before the long hold-off starts
   localparam int PHASE_ITEMS  = 200;
   localparam int STEADY_FROM  = 1000;  // request window with no idling on either side
   localparam int STEADY_UNTIL = 1300;
   localparam logic [CSR_ADDR_W-1:0] BANK_MAP_ADDR =
      CSR_ADDR_W'(4 * int'(bramwm_pkg::CSR_BANK_MAP));

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_operation;
   logic [ADDR_W-1:0]      req_address;
   logic [WORD_W-1:0]      req_write_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [WORD_W-1:0]      rsp_read_data;
   logic                   rsp_mapped;
   logic [ADDR_W-1:0]      rsp_range_low;
   logic [MARK_HIGH_W-1:0] rsp_range_high;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int pending;
   int requests_seen;
   int results_seen;
   int cycle_count = 0;
   int hold_left   = 0;
   bit hold_done   = 0;

   // Stimulus-side view of the block: which bytes hold data, so that no read
   // ever touches a byte that was never written.
   logic [MAP_W-1:0]  cur_map;
   bit                byte_written [0:65535];
   logic [ADDR_W-1:0] word_pool [$];
   int                n_reads  = 0;
   int                n_writes = 0;
   int                n_absent = 0;
   int                n_maps   = 0;

   wire steady = requests_seen >= STEADY_FROM && requests_seen < STEADY_UNTIL;

   banked_ram_with_access_watermarks uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_mapped     (rsp_mapped),
      .rsp_range_low  (rsp_range_low),
      .rsp_range_high (rsp_range_high),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   bramwm_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_mapped     (rsp_mapped),
      .rsp_range_low  (rsp_range_low),
      .rsp_range_high (rsp_range_high),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending        (pending),
      .requests_seen  (requests_seen),
      .results_seen   (results_seen)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles with %0d responses outstanding", CYCLE_LIMIT, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: stall at random, hold off once for a long stretch so the
   // block backs up into the request channel, and never stall in the steady window.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 32);
      end
   end

   function automatic bit is_present(input int bank);
      return bank < DEFAULT_BANK_COUNT && cur_map[bank];
   endfunction

   function automatic bit read_safe(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] addr2;
      addr2 = addr + 16'd1;
      if (!is_present(int'(addr) / DEFAULT_BANK_BYTES)) return 1'b1;
      return byte_written[addr] &&
             (!is_present(int'(addr2) / DEFAULT_BANK_BYTES) || byte_written[addr2]);
   endfunction

   // One APB transfer to the bank map register: setup phase, then access phase.
   task automatic csr_access(input bit write, input logic [MAP_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= BANK_MAP_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Withdraw the last item, drain every outstanding response, then rewrite
   // and read back the bank map.
   task automatic set_bank_map(input logic [MAP_W-1:0] value);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
      cur_map = value;
      n_maps++;
   endtask

   // Offer one item, with a random gap first outside the steady window, and hold it until accepted.
   task automatic send_item(input bramwm_pkg::op_type op, input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] data);
      logic [ADDR_W-1:0] addr2;
      bit                first_ok;
      addr2    = addr + 16'd1;
      first_ok = is_present(int'(addr) / DEFAULT_BANK_BYTES);
      if (!first_ok) n_absent++;
      if (op == bramwm_pkg::OP_WRITE) begin
         n_writes++;
         if (first_ok) begin
            byte_written[addr] = 1'b1;
            if (is_present(int'(addr2) / DEFAULT_BANK_BYTES)) byte_written[addr2] = 1'b1;
            word_pool.push_back(addr);
            if (word_pool.size() > 512) word_pool.delete($urandom_range(0, 511));
         end
      end else begin
         n_reads++;
      end
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_address    <= addr;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Mostly reads of data already written and writes into present banks, with
   // bank edges, the top of memory and stray addresses mixed in.
   task automatic random_item();
      bramwm_pkg::op_type op;
      logic [ADDR_W-1:0]  addr;
      logic [11:0]        offset;
      int                 live [$];
      int                 bank;
      int                 pick;
      op = bramwm_pkg::op_type'($urandom_range(0, 1));
      for (bank = 0; bank < DEFAULT_BANK_COUNT; bank++) begin
         if (is_present(bank)) live.push_back(bank);
      end
      bank = (live.size() > 0 && $urandom_range(0, 99) < 85) ?
             live[$urandom_range(0, live.size() - 1)] : $urandom_range(0, 15);
      pick = $urandom_range(0, 99);
      if (op == bramwm_pkg::OP_READ && word_pool.size() > 0 && pick < 70) begin
         addr = word_pool[$urandom_range(0, word_pool.size() - 1)];
         if ($urandom_range(0, 3) == 0) addr = addr + 16'd1;
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0:       offset = 12'h000;
            1:       offset = 12'h001;
            2:       offset = 12'hFFE;
            default: offset = 12'hFFF;
         endcase
         addr = (pick < 25) ? {4'(bank), offset} : {4'(bank), 12'($urandom)};
      end else begin
         addr = 16'($urandom);
      end
      if (op == bramwm_pkg::OP_READ && !read_safe(addr)) op = bramwm_pkg::OP_WRITE;
      send_item(op, addr, 16'($urandom));
   endtask

   initial begin : stimulus
      logic [MAP_W-1:0] phase_maps [8];
      int               p;
      int               n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = bramwm_pkg::OP_READ;
      req_address    = '0;
      req_write_data = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      cur_map        = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset value of the map, and accesses while no bank is present.
      csr_access(1'b0, '0);
      send_item(bramwm_pkg::OP_READ, 16'h0000, 16'h0000);
      send_item(bramwm_pkg::OP_WRITE, 16'hFFFF, 16'hBEEF);
      send_item(bramwm_pkg::OP_READ, 16'h8001, 16'h0000);

      // All banks present: field extremes, the wrap at the top of memory, and
      // words that straddle a bank boundary.
      set_bank_map(16'hFFFF);
      send_item(bramwm_pkg::OP_WRITE, 16'h0000, 16'h0000);
      send_item(bramwm_pkg::OP_WRITE, 16'hFFFF, 16'hFFFF);
      send_item(bramwm_pkg::OP_READ, 16'hFFFF, 16'h0000);
      send_item(bramwm_pkg::OP_READ, 16'h0000, 16'hFFFF);
      send_item(bramwm_pkg::OP_WRITE, 16'h0FFF, 16'hA55A);
      send_item(bramwm_pkg::OP_READ, 16'h0FFF, 16'h0000);
      send_item(bramwm_pkg::OP_WRITE, 16'h7FFF, 16'h8001);
      send_item(bramwm_pkg::OP_READ, 16'h7FFF, 16'h0000);
      send_item(bramwm_pkg::OP_WRITE, 16'h1000, 16'h5AA5);
      send_item(bramwm_pkg::OP_WRITE, 16'hFFFE, 16'h1234);
      send_item(bramwm_pkg::OP_READ, 16'hFFFE, 16'h0000);

      // Even banks only: second byte lands in an absent bank, or the first does.
      set_bank_map(16'h5555);
      send_item(bramwm_pkg::OP_WRITE, 16'h0FFF, 16'hC3C3);
      send_item(bramwm_pkg::OP_READ, 16'h0FFF, 16'h0000);
      send_item(bramwm_pkg::OP_READ, 16'h1000, 16'h0000);
      send_item(bramwm_pkg::OP_WRITE, 16'hEFFF, 16'h7E7E);
      send_item(bramwm_pkg::OP_READ, 16'hEFFF, 16'h0000);
      send_item(bramwm_pkg::OP_READ, 16'hFFFF, 16'h0000);
      send_item(bramwm_pkg::OP_READ, 16'h0000, 16'h0000);

      // Odd banks only: top-of-memory wrap into an absent bank 0; old data kept.
      set_bank_map(16'hAAAA);
      send_item(bramwm_pkg::OP_READ, 16'hFFFF, 16'h0000);
      send_item(bramwm_pkg::OP_WRITE, 16'h1FFF, 16'h0102);
      send_item(bramwm_pkg::OP_READ, 16'h1FFF, 16'h0000);
      send_item(bramwm_pkg::OP_READ, 16'h1000, 16'h0000);

      // Random phases, each under its own bank map; the sender drains fully
      // before every map change.
      phase_maps[0] = 16'hFFFF;
      phase_maps[1] = 16'h0001;
      phase_maps[2] = 16'h8000;
      phase_maps[3] = 16'($urandom);
      phase_maps[4] = 16'h0F0F;
      phase_maps[5] = 16'($urandom);
      phase_maps[6] = 16'hF0F0;
      phase_maps[7] = 16'hFFFF;
      for (p = 0; p < 8; p++) begin
         set_bank_map(phase_maps[p]);
         for (n = 0; n < PHASE_ITEMS; n++) random_item();
      end
      set_bank_map(16'h0000);
      req_valid <= 1'b0;

      // Wait out the last responses, then keep watching for any stray one.
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Covered %0d items: %0d reads, %0d writes, %0d with the first bank absent.",
               n_reads + n_writes, n_reads, n_writes, n_absent);
      $display("Checked %0d responses across %0d bank map settings; %0d mismatches.",
               results_seen, n_maps, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
design/bramwm_pkg.sv
design/banked_ram_with_access_watermarks.sv
design/bramwm_checker.sv
test/bramwm_checker.sv
test/banked_ram_with_access_watermarks_tb.sv
